[src/cicd_pkg.sv]
// Shared types and constants of the multichannel CIC decimator.
`timescale 1ns / 1ps

package cicd_pkg;

  // Configuration register widths.
  localparam int RATIO_W = 13;
  localparam int DELAY_W = 2;
  localparam int SHIFT_W = 6;

  // Register map, one 32-bit word per register.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_RATIO = 2'd0,
    REG_DELAY = 2'd1,
    REG_SHIFT = 2'd2
  } reg_idx_t;

  // Delay code that selects the two-frame comb tap.
  localparam logic [DELAY_W-1:0] DELAY_TWO = 2'd2;

  // Depth of the queue between the integrator and comb sections.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Live configuration seen by both sections.
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [DELAY_W-1:0] delay;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  // Queue status toward its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/multichannel_cic_decimator_unit.sv]
// Path of a kept sample: integrator stages, queue, comb stages and output register.
// Throughput: one sample per cycle while in_stall is low; each integrator and comb
// stage is one add or subtract per cycle on a rotating per-channel register line, and
// the four-entry queue absorbs output stalls.
// Reset (synchronous, active low) clears all accumulators, comb histories, the frame
// counter, the queue and the configuration (ratio 1, delay 1, shift 0).
`timescale 1ns / 1ps

module multichannel_cic_decimator_unit #(
  parameter int STAGES    = 5,
  parameter int CHANNELS  = 16,
  parameter int IN_WIDTH  = 16,
  parameter int ACC_WIDTH = 48,
  parameter int OUT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cicd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cicd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cicd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [IN_WIDTH-1:0]          in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [OUT_WIDTH-1:0]         out_filtered
);

  cicd_pkg::cfg_t     cfg_r;
  cicd_pkg::reg_idx_t reg_idx;
  cicd_pkg::q_stat_t  q_stat;
  logic               wr_en;
  logic               q_push;
  logic               q_pop;
  logic [ACC_WIDTH-1:0] q_wdata;
  logic [ACC_WIDTH-1:0] q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cicd_pkg::reg_idx_t'(paddr[3:2]);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio <= cicd_pkg::RATIO_W'(1);
      cfg_r.delay <= cicd_pkg::DELAY_W'(1);
      cfg_r.shift <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        cicd_pkg::REG_RATIO: cfg_r.ratio <= pwdata[cicd_pkg::RATIO_W-1:0];
        cicd_pkg::REG_DELAY: cfg_r.delay <= pwdata[cicd_pkg::DELAY_W-1:0];
        cicd_pkg::REG_SHIFT: cfg_r.shift <= pwdata[cicd_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      cicd_pkg::REG_RATIO: prdata = cicd_pkg::APB_DATA_W'(cfg_r.ratio);
      cicd_pkg::REG_DELAY: prdata = cicd_pkg::APB_DATA_W'(cfg_r.delay);
      cicd_pkg::REG_SHIFT: prdata = cicd_pkg::APB_DATA_W'(cfg_r.shift);
      default:             prdata = '0;
    endcase
  end

  cicd_front #(
    .STAGES   (STAGES),
    .CHANNELS (CHANNELS),
    .IN_WIDTH (IN_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  cicd_fifo #(
    .WIDTH(ACC_WIDTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  cicd_back #(
    .STAGES   (STAGES),
    .CHANNELS (CHANNELS),
    .ACC_WIDTH(ACC_WIDTH),
    .OUT_WIDTH(OUT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_stat      (q_stat),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_filtered(out_filtered)
  );

  // The integrator section never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The comb section never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // Input back-pressure only comes from a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule

[src/cicd_front.sv]
// Integrator section: per-channel integrator cascade and frame keep decision.
`timescale 1ns / 1ps

module cicd_front #(
  parameter int STAGES    = 5,
  parameter int CHANNELS  = 16,
  parameter int IN_WIDTH  = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cicd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [IN_WIDTH-1:0]  in_sample,
  input  cicd_pkg::q_stat_t           q_stat,
  output logic                        q_push,
  output logic [ACC_WIDTH-1:0]        q_wdata
);

  // Frame position covers the largest frame of all ratios and channels.
  localparam int FPW = $clog2(((1 << cicd_pkg::RATIO_W) - 1) * CHANNELS + 1);
  localparam logic [FPW-1:0] CH_F = FPW'(CHANNELS);

  logic [FPW-1:0]       pos_r;
  logic [FPW-1:0]       pos_inc;
  logic [FPW-1:0]       frame_len;
  logic [cicd_pkg::RATIO_W-1:0] ratio_eff;
  logic                 keep_nxt;
  logic                 adv;
  logic                 in_take;

  logic [ACC_WIDTH-1:0] st_data_r [STAGES];
  logic                 st_vld_r  [STAGES];
  logic                 st_keep_r [STAGES];

  logic [ACC_WIDTH-1:0] stg_in_data [STAGES];
  logic                 stg_in_vld  [STAGES];
  logic                 stg_in_keep [STAGES];

  // The whole cascade moves unless a kept transaction waits on a full queue.
  assign adv      = !(st_vld_r[STAGES-1] && st_keep_r[STAGES-1] && q_stat.full);
  assign in_stall = !adv;
  assign in_take  = in_valid && adv;

  assign q_push  = adv && st_vld_r[STAGES-1] && st_keep_r[STAGES-1];
  assign q_wdata = st_data_r[STAGES-1];

  // Frame length and keep decision for the incoming sample.
  always_comb begin
    ratio_eff = (cfg.ratio == '0) ? cicd_pkg::RATIO_W'(1) : cfg.ratio;
    frame_len = FPW'(ratio_eff) * CH_F;
    pos_inc   = pos_r + FPW'(1);
    keep_nxt  = pos_r < CH_F;
  end

  // Frame position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_take) begin
      pos_r <= (pos_inc >= frame_len) ? '0 : pos_inc;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < STAGES; gi++) begin : g_stage
      // Rotating line of accumulators; entry zero belongs to the channel at hand.
      logic [ACC_WIDTH-1:0] acc_r [CHANNELS];
      logic [ACC_WIDTH-1:0] sum_nxt;
      logic                 rot;

      if (gi == 0) begin : g_head
        assign stg_in_data[gi] = ACC_WIDTH'(in_sample);
        assign stg_in_vld[gi]  = in_valid;
        assign stg_in_keep[gi] = keep_nxt;
      end else begin : g_chain
        assign stg_in_data[gi] = st_data_r[gi-1];
        assign stg_in_vld[gi]  = st_vld_r[gi-1];
        assign stg_in_keep[gi] = st_keep_r[gi-1];
      end

      assign sum_nxt = acc_r[0] + stg_in_data[gi];
      assign rot     = adv && stg_in_vld[gi];

      // Accumulator update; the line turns by one channel per transaction.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int k = 0; k < CHANNELS; k++) begin
            acc_r[k] <= '0;
          end
        end else if (rot) begin
          for (int k = 0; k < CHANNELS - 1; k++) begin
            acc_r[k] <= acc_r[k+1];
          end
          acc_r[CHANNELS-1] <= sum_nxt;
        end
      end

      // Stage control.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_vld_r[gi]  <= 1'b0;
          st_keep_r[gi] <= 1'b0;
        end else if (adv) begin
          st_vld_r[gi]  <= stg_in_vld[gi];
          st_keep_r[gi] <= stg_in_keep[gi];
        end
      end

      // Stage payload.
      always_ff @(posedge clk) begin
        if (rot) begin
          st_data_r[gi] <= sum_nxt;
        end
      end
    end
  endgenerate

endmodule

[src/cicd_fifo.sv]
// Short queue that decouples the integrator and comb sections.
`timescale 1ns / 1ps

module cicd_fifo #(
  parameter int WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output cicd_pkg::q_stat_t stat
);

  localparam int CNT_W = cicd_pkg::QPTR_W + 1;

  logic [WIDTH-1:0]            mem_r [cicd_pkg::QDEPTH];
  logic [cicd_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [cicd_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0]            cnt_r;

  assign stat.full  = cnt_r == CNT_W'(cicd_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign rdata      = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cicd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cicd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/cicd_back.sv]
// Comb section: per-channel comb cascade, output shift and output register.
`timescale 1ns / 1ps

module cicd_back #(
  parameter int STAGES    = 5,
  parameter int CHANNELS  = 16,
  parameter int ACC_WIDTH = 48,
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cicd_pkg::cfg_t              cfg,
  input  cicd_pkg::q_stat_t           q_stat,
  input  logic [ACC_WIDTH-1:0]        q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] out_filtered
);

  localparam logic [cicd_pkg::SHIFT_W:0] ACC_LIM = (cicd_pkg::SHIFT_W + 1)'(ACC_WIDTH);

  logic                 adv;
  logic                 two;
  logic                 out_vld_r;
  logic signed [OUT_WIDTH-1:0] out_data_r;
  logic signed [ACC_WIDTH-1:0] shifted;
  logic signed [ACC_WIDTH-1:0] last_val;

  logic [ACC_WIDTH-1:0] st_data_r [STAGES];
  logic                 st_vld_r  [STAGES];

  logic [ACC_WIDTH-1:0] stg_in_data [STAGES];
  logic                 stg_in_vld  [STAGES];

  // The cascade moves unless a finished transaction waits at the output.
  assign adv   = !(out_vld_r && out_stall);
  assign q_pop = adv && !q_stat.empty;
  assign two   = cfg.delay == cicd_pkg::DELAY_TWO;

  assign out_valid    = out_vld_r;
  assign out_filtered = out_data_r;

  genvar gi;
  generate
    for (gi = 0; gi < STAGES; gi++) begin : g_stage
      // Rotating line of two-slot histories; entry zero is the channel at hand.
      logic [ACC_WIDTH-1:0] h0_r [CHANNELS];
      logic [ACC_WIDTH-1:0] h1_r [CHANNELS];
      logic [ACC_WIDTH-1:0] tap;
      logic [ACC_WIDTH-1:0] diff_nxt;
      logic                 rot;

      if (gi == 0) begin : g_head
        assign stg_in_data[gi] = q_rdata;
        assign stg_in_vld[gi]  = !q_stat.empty;
      end else begin : g_chain
        assign stg_in_data[gi] = st_data_r[gi-1];
        assign stg_in_vld[gi]  = st_vld_r[gi-1];
      end

      assign tap      = two ? h1_r[0] : h0_r[0];
      assign diff_nxt = stg_in_data[gi] - tap;
      assign rot      = adv && stg_in_vld[gi];

      // Both slots always shift; the delay code only picks the tap.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int k = 0; k < CHANNELS; k++) begin
            h0_r[k] <= '0;
            h1_r[k] <= '0;
          end
        end else if (rot) begin
          for (int k = 0; k < CHANNELS - 1; k++) begin
            h0_r[k] <= h0_r[k+1];
            h1_r[k] <= h1_r[k+1];
          end
          h0_r[CHANNELS-1] <= stg_in_data[gi];
          h1_r[CHANNELS-1] <= h0_r[0];
        end
      end

      // Stage control.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_vld_r[gi] <= 1'b0;
        end else if (adv) begin
          st_vld_r[gi] <= stg_in_vld[gi];
        end
      end

      // Stage payload.
      always_ff @(posedge clk) begin
        if (rot) begin
          st_data_r[gi] <= diff_nxt;
        end
      end
    end
  endgenerate

  // Arithmetic right shift; a shift at or beyond the accumulator width gives sign bits.
  always_comb begin
    last_val = $signed(st_data_r[STAGES-1]);
    if ({1'b0, cfg.shift} >= ACC_LIM) begin
      shifted = {ACC_WIDTH{last_val[ACC_WIDTH-1]}};
    end else begin
      shifted = last_val >>> cfg.shift;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= st_vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_vld_r[STAGES-1]) begin
      out_data_r <= OUT_WIDTH'(shifted);
    end
  end

endmodule

[dv/multichannel_cic_decimator_unit_test.sv]
// Self-checking testbench for the multichannel CIC decimator unit.
`timescale 1ns / 1ps

module multichannel_cic_decimator_unit_test;

  localparam int STAGES = 5;
  localparam int CHANNELS = 16;
  localparam int IN_W = 16;
  localparam int ACC_W = 48;
  localparam int OUT_W = 16;
  localparam int LATENCY = 2 * STAGES + 2;
  localparam int SETTLE_CYCLES = 4 * LATENCY;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [cicd_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [cicd_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [cicd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_filtered;

  // Shadow copy of the filter state and the live configuration.
  logic [ACC_W-1:0] integ_sum [STAGES][CHANNELS];
  logic [ACC_W-1:0] comb_hist [STAGES][CHANNELS][2];
  int unsigned frame_pos;
  int unsigned integ_ch;
  int unsigned comb_ch;
  logic [cicd_pkg::RATIO_W-1:0] ratio_cfg;
  logic [cicd_pkg::DELAY_W-1:0] delay_cfg;
  logic [cicd_pkg::SHIFT_W-1:0] shift_cfg;

  // Filtered values still owed by the block, oldest first.
  logic [OUT_W-1:0] filtered_expected [$];

  int n_errors = 0;
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  logic stall_level = 1'b0;

  multichannel_cic_decimator_unit #(
    .STAGES(STAGES),
    .CHANNELS(CHANNELS),
    .IN_WIDTH(IN_W),
    .ACC_WIDTH(ACC_W),
    .OUT_WIDTH(OUT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_filtered(out_filtered)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clear the shadow state to its post-reset values.
  task automatic model_reset();
    for (int s = 0; s < STAGES; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        integ_sum[s][c] = '0;
        comb_hist[s][c][0] = '0;
        comb_hist[s][c][1] = '0;
      end
    end
    frame_pos = 0;
    integ_ch = 0;
    comb_ch = 0;
    ratio_cfg = 1;
    delay_cfg = 1;
    shift_cfg = 0;
  endtask

  // Run one accepted sample through the integrators, the frame decimator and
  // the combs, and queue the filtered value when the sample is kept.
  function automatic void cic_predict_sample(input logic [IN_W-1:0] s);
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] tap;
    logic signed [ACC_W-1:0] sx;
    int unsigned ch;
    int unsigned cc;
    int unsigned ratio_eff;
    int unsigned frame_len;
    bit keep;
    x = {{(ACC_W - IN_W){s[IN_W-1]}}, s};
    ch = integ_ch % CHANNELS;
    for (int i = 0; i < STAGES; i++) begin
      integ_sum[i][ch] = integ_sum[i][ch] + x;
      x = integ_sum[i][ch];
    end
    ratio_eff = (ratio_cfg == 0) ? 1 : ratio_cfg;
    frame_len = ratio_eff * CHANNELS;
    keep = frame_pos < CHANNELS;
    frame_pos = (frame_pos + 1 >= frame_len) ? 0 : frame_pos + 1;
    integ_ch = (ch + 1) % CHANNELS;
    if (!keep) return;
    // Both history slots always shift; the delay code only picks the tap.
    cc = comb_ch % CHANNELS;
    for (int i = 0; i < STAGES; i++) begin
      tap = (delay_cfg == cicd_pkg::DELAY_TWO) ? comb_hist[i][cc][1] : comb_hist[i][cc][0];
      comb_hist[i][cc][1] = comb_hist[i][cc][0];
      comb_hist[i][cc][0] = x;
      x = x - tap;
    end
    comb_ch = (cc + 1) % CHANNELS;
    if (shift_cfg >= ACC_W) begin
      x = {ACC_W{x[ACC_W-1]}};
    end else begin
      sx = x;
      x = sx >>> shift_cfg;
    end
    filtered_expected.push_back(x[OUT_W-1:0]);
  endfunction

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_expected.size() == 0) begin
        $error("filtered: no result expected, actual %0d", out_filtered);
        n_errors++;
      end else begin
        want = filtered_expected.pop_front();
        if (out_filtered !== want) begin
          $error("filtered: expected %0d, actual %0d", $signed(want), out_filtered);
          n_errors++;
        end
      end
    end
  end

  // Random backpressure on the result side: mostly short stalls, a few long.
  always @(negedge clk) begin : drive_stall
    int pick;
    if (!stall_on) begin
      stall_left = 0;
      stall_level = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(0, 5);
      end else if (pick < 85) begin
        stall_level = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (pick < 97) begin
        stall_level = 1'b1;
        stall_left = $urandom_range(3, 11);
      end else begin
        stall_level = 1'b1;
        stall_left = $urandom_range(19, 59);
      end
    end
    out_stall <= stall_level;
  end

  // One APB transaction: setup cycle, then access until pready.
  task automatic apb_xfer(input bit wr, input cicd_pkg::reg_idx_t idx,
                          input logic [cicd_pkg::APB_DATA_W-1:0] wdata,
                          output logic [cicd_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Read one register back and compare it with the shadow configuration.
  task automatic cfg_read_check(input cicd_pkg::reg_idx_t idx);
    logic [cicd_pkg::APB_DATA_W-1:0] rd;
    int unsigned want;
    int unsigned got;
    apb_xfer(1'b0, idx, '0, rd);
    case (idx)
      cicd_pkg::REG_RATIO: begin
        want = ratio_cfg;
        got = rd[cicd_pkg::RATIO_W-1:0];
      end
      cicd_pkg::REG_DELAY: begin
        want = delay_cfg;
        got = rd[cicd_pkg::DELAY_W-1:0];
      end
      default: begin
        want = shift_cfg;
        got = rd[cicd_pkg::SHIFT_W-1:0];
      end
    endcase
    if (want != got) begin
      $error("%s readback: expected %0d, actual %0d", idx.name(), want, got);
      n_errors++;
    end
  endtask

  // Write one register, track it in the shadow copy and read it back.
  task automatic cfg_write(input cicd_pkg::reg_idx_t idx, input int unsigned val);
    logic [cicd_pkg::APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, idx, cicd_pkg::APB_DATA_W'(val), rd);
    case (idx)
      cicd_pkg::REG_RATIO: ratio_cfg = val[cicd_pkg::RATIO_W-1:0];
      cicd_pkg::REG_DELAY: delay_cfg = val[cicd_pkg::DELAY_W-1:0];
      default: shift_cfg = val[cicd_pkg::SHIFT_W-1:0];
    endcase
    cfg_read_check(idx);
  endtask

  task automatic cfg_write_all(input int unsigned ratio, input int unsigned delay,
                               input int unsigned shift);
    cfg_write(cicd_pkg::REG_RATIO, ratio);
    cfg_write(cicd_pkg::REG_DELAY, delay);
    cfg_write(cicd_pkg::REG_SHIFT, shift);
  endtask

  // Present one sample and hold it until the block takes the transaction.
  task automatic send_sample(input logic [IN_W-1:0] s);
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    cic_predict_sample(s);
  endtask

  // Hold the input idle, n being the length of the gap.
  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int gap_len();
    int pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_paced(input logic [IN_W-1:0] s);
    send_sample(s);
    pause_input(gap_len());
  endtask

  // Stop sending until every owed result is out, then let the pipeline empty.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(IN_W - 1){1'b1}}};
      1: return {1'b1, {(IN_W - 1){1'b0}}};
      2, 3, 4: return IN_W'($urandom_range(0, 15) - 8);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // Registers come out of reset with ratio 1, delay 1 and no shift.
  task automatic test_register_defaults();
    cfg_read_check(cicd_pkg::REG_RATIO);
    cfg_read_check(cicd_pkg::REG_DELAY);
    cfg_read_check(cicd_pkg::REG_SHIFT);
  endtask

  // Full-scale and bit-pattern samples with every sample kept.
  task automatic test_sample_extremes();
    logic [IN_W-1:0] pattern [10];
    pattern = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000};
    foreach (pattern[i]) send_sample(pattern[i]);
    drain_results();
  endtask

  // Ratio zero, odd delay codes, two-frame delay and shifts at and past the width.
  task automatic test_config_corners();
    cfg_write_all(0, 3, 47);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF);
    drain_results();
    cfg_write_all(0, cicd_pkg::DELAY_TWO, 63);
    for (int i = 0; i < 5; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000);
    drain_results();
    cfg_write_all(2, 0, 48);
    for (int i = 0; i < 4; i++) send_sample(rand_sample());
    drain_results();
  endtask

  // Shrink the ratio while the frame counter sits past the new frame length.
  task automatic test_ratio_shrink();
    cfg_write_all(8, 1, 20);
    for (int i = 0; i < 60; i++) send_paced(rand_sample());
    drain_results();
    cfg_write(cicd_pkg::REG_RATIO, 2);
    for (int i = 0; i < 60; i++) send_paced(rand_sample());
    drain_results();
  endtask

  // Random settings per phase, random samples, random gaps and stalls.
  task automatic test_random_traffic();
    int unsigned ratio;
    int unsigned shift;
    int hold_at;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 9))
        0: ratio = 0;
        1: ratio = $urandom_range(9, 40);
        default: ratio = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: shift = $urandom_range(48, 63);
        1, 2: shift = $urandom_range(21, 47);
        default: shift = $urandom_range(0, 20);
      endcase
      cfg_write_all(ratio, $urandom_range(0, 3), shift);
      gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      stall_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      hold_at = $urandom_range(10, 50);
      for (int i = 0; i < 60; i++) begin
        if (i == hold_at) drain_results();
        send_paced(rand_sample());
      end
      drain_results();
    end
  endtask

  // The largest nominal ratio and the largest the register holds: the first
  // frame is kept and the frames after it are dropped.
  task automatic test_long_ratios();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    cfg_write_all(4096, 1, $urandom_range(0, 47));
    for (int i = 0; i < 3 * CHANNELS; i++) send_sample(IN_W'($urandom));
    drain_results();
    cfg_write_all(8191, cicd_pkg::DELAY_TWO, $urandom_range(0, 47));
    for (int i = 0; i < 3 * CHANNELS; i++) send_sample(IN_W'($urandom));
    drain_results();
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_register_defaults();
    test_sample_extremes();
    test_config_corners();
    test_ratio_shrink();
    test_random_traffic();
    test_long_ratios();
    drain_results();
    if (n_errors == 0) begin
      $display("multichannel_cic_decimator_unit_test OK");
    end else begin
      $display("multichannel_cic_decimator_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("multichannel_cic_decimator_unit_test NOT OK");
    $finish;
  end

endmodule
